// File: design/ssd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ssd_pkg;

  // Digit codes held for each display position
  typedef logic [3:0] code_t;
  typedef code_t [7:0] codes_t;

  localparam code_t CODE_F     = 4'd10;
  localparam code_t CODE_E     = 4'd11;
  localparam code_t CODE_BLANK = 4'd12;

  // Request kinds on the input stream
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_SCAN   = 1'b1;

  // Pages
  localparam logic PAGE_FREQ  = 1'b0;
  localparam logic PAGE_LIGHT = 1'b1;

  // Decimal point is lit on this digit of the light page
  localparam logic [2:0] DP_DIGIT    = 3'd6;
  localparam logic [7:0] SEG_DP_MASK = 8'h7F;

  // Largest value shown in a two-digit field
  localparam logic [6:0] TWO_DIGIT_MAX = 7'd99;

  // Reciprocal constants for division by constants
  localparam logic [16:0] RECIP_DIV100_W16 = 17'd83887;  // x/100 = (x*m)>>23, x < 2^16
  localparam logic [5:0]  RECIP_DIV100_W10 = 6'd41;      // x/100 = (x*m)>>12, x < 1024
  localparam logic [7:0]  RECIP_DIV10      = 8'd205;     // x/10  = (x*m)>>11, x < 1024

  // Write of a whole page into the digit store
  typedef struct packed {
    logic   page;
    codes_t codes;
  } page_write_t;

  // Active-low segment pattern for a digit code
  function automatic logic [7:0] seg_pattern(input code_t code);
    logic [7:0] seg;
    case (code)
      4'd0:    seg = 8'hC0;
      4'd1:    seg = 8'hF9;
      4'd2:    seg = 8'hA4;
      4'd3:    seg = 8'hB0;
      4'd4:    seg = 8'h99;
      4'd5:    seg = 8'h92;
      4'd6:    seg = 8'h82;
      4'd7:    seg = 8'hF8;
      4'd8:    seg = 8'h80;
      4'd9:    seg = 8'h90;
      CODE_F:  seg = 8'h8E;
      CODE_E:  seg = 8'h86;
      default: seg = 8'hFF;
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

// File: design/ssd_freq_digits.sv
`timescale 1ns / 1ps
`default_nettype none

// Three-stage split of a 16-bit value into five decimal digits.
// digits[4] is the ten-thousands digit, digits[0] the ones digit.
module ssd_freq_digits (
  input  wire logic                clk,
  input  wire logic                advance,
  input  wire logic [15:0]         freq,
  output ssd_pkg::code_t [4:0]     digits
);

  // Stage A: f / 100 by reciprocal
  logic [32:0] prod_a;
  logic [9:0]  q1_b;
  logic [15:0] freq_b;

  assign prod_a = freq * ssd_pkg::RECIP_DIV100_W16;

  // Stage B: remainder of f / 100, then q1 / 100 and q1 / 10
  logic [15:0] hund_b;
  logic [15:0] prod_q2_b;
  logic [17:0] prod_q10_b;
  logic [6:0]  r1_c;
  logic [2:0]  q2_c;
  logic [6:0]  q10_c;
  logic [9:0]  q1_c;

  assign hund_b     = 16'(q1_b * 7'd100);
  assign prod_q2_b  = q1_b * ssd_pkg::RECIP_DIV100_W10;
  assign prod_q10_b = q1_b * ssd_pkg::RECIP_DIV10;

  // Stage C: upper digits and tens of the low remainder
  logic [6:0]  d3_c;
  logic [9:0]  d2_c;
  logic [14:0] prod_d1_c;
  logic [3:0]  d4_d;
  logic [3:0]  d3_d;
  logic [3:0]  d2_d;
  logic [3:0]  d1_d;
  logic [6:0]  r1_d;

  assign d3_c      = q10_c - 7'(q2_c * 4'd10);
  assign d2_c      = q1_c - 10'(q10_c * 4'd10);
  assign prod_d1_c = r1_c * ssd_pkg::RECIP_DIV10;

  always_ff @(posedge clk) begin
    if (advance) begin
      q1_b   <= prod_a[32:23];
      freq_b <= freq;

      r1_c   <= 7'(freq_b - hund_b);
      q2_c   <= prod_q2_b[14:12];
      q10_c  <= prod_q10_b[17:11];
      q1_c   <= q1_b;

      d4_d   <= {1'b0, q2_c};
      d3_d   <= d3_c[3:0];
      d2_d   <= d2_c[3:0];
      d1_d   <= prod_d1_c[14:11];
      r1_d   <= r1_c;
    end
  end

  // Ones digit falls out of the registered remainder
  logic [6:0] d0;
  assign d0 = r1_d - 7'(d1_d * 4'd10);

  assign digits = {d4_d, d3_d, d2_d, d1_d, d0[3:0]};

endmodule

`default_nettype wire

// File: design/ssd_display.sv
`timescale 1ns / 1ps
`default_nettype none

// Digit store, shown page, scan position and the result register.
module ssd_display (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 req_valid,
  input  wire logic                 req_op,
  input  wire ssd_pkg::page_write_t wr,
  input  wire logic                 out_ready,
  output logic                      out_valid,
  output logic [7:0]                out_select,
  output logic [7:0]                out_segments,
  output logic                      advance
);

  ssd_pkg::codes_t codes;
  logic            shown_page;
  logic [2:0]      scan_pos;

  // Whole pipeline moves when the result register is free or being drained
  assign advance = !out_valid || out_ready;

  // Segment lookup for the digit under the scan
  logic [7:0] seg_raw;
  logic [7:0] seg_next;
  logic [7:0] select_next;

  assign seg_raw     = ssd_pkg::seg_pattern(codes[scan_pos]);
  assign seg_next    = (shown_page == ssd_pkg::PAGE_LIGHT && scan_pos == ssd_pkg::DP_DIGIT)
                       ? (seg_raw & ssd_pkg::SEG_DP_MASK) : seg_raw;
  assign select_next = 8'd1 << scan_pos;

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      codes      <= {8{ssd_pkg::CODE_BLANK}};
      shown_page <= ssd_pkg::PAGE_FREQ;
      scan_pos   <= 3'd0;
      out_valid  <= 1'b0;
    end else if (advance) begin
      out_valid <= req_valid && req_op == ssd_pkg::OP_SCAN;
      if (req_valid && req_op == ssd_pkg::OP_UPDATE) begin
        codes      <= wr.codes;
        shown_page <= wr.page;
      end
      if (req_valid && req_op == ssd_pkg::OP_SCAN) begin
        scan_pos <= scan_pos + 3'd1;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (advance && req_valid && req_op == ssd_pkg::OP_SCAN) begin
      out_select   <= select_next;
      out_segments <= seg_next;
    end
  end

  // Checks
  a_select_onehot: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot(out_select))
    else $error("digit select not one-hot");

  a_dp_only_digit6: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_segments[7] |-> out_select == 8'h40)
    else $error("decimal point lit outside digit 6");

  a_scan_steps: assert property (@(posedge clk) disable iff (rst)
    advance && req_valid && req_op == ssd_pkg::OP_SCAN |=> scan_pos == $past(scan_pos) + 3'd1)
    else $error("scan position did not step");

  a_update_holds_scan: assert property (@(posedge clk) disable iff (rst)
    advance && req_valid && req_op == ssd_pkg::OP_UPDATE |=> $stable(scan_pos) && !out_valid)
    else $error("update moved the scan or produced a result");

endmodule

`default_nettype wire

// File: design/seven_segment_two_page_display.sv
`timescale 1ns / 1ps
`default_nettype none

// Two-page driver for an 8-digit multiplexed common-anode seven-segment display.
// An update request (tuser[0] = 0) stores a page: page 0 shows 'F', the key value
// and the frequency with leading zeros blanked; page 1 shows 'E', the key value and
// the light value (capped at 99) with the decimal point on digit 6. A scan request
// (tuser[0] = 1) returns the one-hot select and active-low segments of the next
// digit and steps the scan. One request is taken every cycle while the result side
// keeps up; a result passes the input register, the stage registers 2, 3 and 4 and
// the result register, with the frequency going through the three-stage decimal split. s_tready
// follows the result register: it drops only while a result waits on m_tready.
module seven_segment_two_page_display (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [31:0] s_tdata,   // key_number[6:0], frequency[22:7], light_level[29:23]
  input  wire logic [1:0]  s_tuser,   // operation[0], page[1]
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata    // digit_select[7:0], segments[15:8]
);

  logic advance;

  // Input register
  logic        v1;
  logic        op1;
  logic        page1;
  logic [6:0]  key1;
  logic [15:0] freq1;
  logic [6:0]  light1;

  // Stage A: saturate, tens by reciprocal
  logic [6:0]  key_sat_a;
  logic [6:0]  light_sat_a;
  logic [14:0] key_prod_a;
  logic [14:0] light_prod_a;

  assign key_sat_a    = (key1 > ssd_pkg::TWO_DIGIT_MAX) ? ssd_pkg::TWO_DIGIT_MAX : key1;
  assign light_sat_a  = (light1 > ssd_pkg::TWO_DIGIT_MAX) ? ssd_pkg::TWO_DIGIT_MAX : light1;
  assign key_prod_a   = key_sat_a * ssd_pkg::RECIP_DIV10;
  assign light_prod_a = light_sat_a * ssd_pkg::RECIP_DIV10;

  logic       v2;
  logic       op2;
  logic       page2;
  logic [6:0] key_sat2;
  logic [3:0] key_t2;
  logic [6:0] light_sat2;
  logic [3:0] light_t2;

  // Stage B: ones digits
  logic [6:0] key_o_b;
  logic [6:0] light_o_b;

  assign key_o_b   = key_sat2 - 7'(key_t2 * 4'd10);
  assign light_o_b = light_sat2 - 7'(light_t2 * 4'd10);

  logic       v3;
  logic       op3;
  logic       page3;
  logic [3:0] key_t3;
  logic [3:0] key_o3;
  logic [3:0] light_t3;
  logic [3:0] light_o3;

  logic       v4;
  logic       op4;
  logic       page4;
  logic [3:0] key_t4;
  logic [3:0] key_o4;
  logic [3:0] light_t4;
  logic [3:0] light_o4;

  // Pipeline valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else if (advance) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    if (advance) begin
      op1        <= s_tuser[0];
      page1      <= s_tuser[1];
      key1       <= s_tdata[6:0];
      freq1      <= s_tdata[22:7];
      light1     <= s_tdata[29:23];

      op2        <= op1;
      page2      <= page1;
      key_sat2   <= key_sat_a;
      key_t2     <= key_prod_a[14:11];
      light_sat2 <= light_sat_a;
      light_t2   <= light_prod_a[14:11];

      op3        <= op2;
      page3      <= page2;
      key_t3     <= key_t2;
      key_o3     <= key_o_b[3:0];
      light_t3   <= light_t2;
      light_o3   <= light_o_b[3:0];

      op4        <= op3;
      page4      <= page3;
      key_t4     <= key_t3;
      key_o4     <= key_o3;
      light_t4   <= light_t3;
      light_o4   <= light_o3;
    end
  end

  assign s_tready = advance;

  // Frequency digits, aligned with stage 4
  ssd_pkg::code_t [4:0] fdig;

  ssd_freq_digits u_freq (
    .clk     (clk),
    .advance (advance),
    .freq    (freq1),
    .digits  (fdig)
  );

  // Page layout with blanking
  ssd_pkg::page_write_t wr;
  logic                 key_zero;
  logic [4:0]           lead;

  assign key_zero = (key_t4 == 4'd0) && (key_o4 == 4'd0);

  always_comb begin
    lead[4] = (fdig[4] == 4'd0);
    lead[3] = lead[4] && (fdig[3] == 4'd0);
    lead[2] = lead[3] && (fdig[2] == 4'd0);
    lead[1] = lead[2] && (fdig[1] == 4'd0);
    lead[0] = 1'b0;

    wr.page     = page4;
    wr.codes[1] = (key_t4 == 4'd0) ? ssd_pkg::CODE_BLANK : key_t4;
    wr.codes[2] = key_zero ? ssd_pkg::CODE_BLANK : key_o4;
    if (page4 == ssd_pkg::PAGE_FREQ) begin
      wr.codes[0] = ssd_pkg::CODE_F;
      wr.codes[3] = lead[4] ? ssd_pkg::CODE_BLANK : fdig[4];
      wr.codes[4] = lead[3] ? ssd_pkg::CODE_BLANK : fdig[3];
      wr.codes[5] = lead[2] ? ssd_pkg::CODE_BLANK : fdig[2];
      wr.codes[6] = lead[1] ? ssd_pkg::CODE_BLANK : fdig[1];
      wr.codes[7] = lead[0] ? ssd_pkg::CODE_BLANK : fdig[0];
    end else begin
      wr.codes[0] = ssd_pkg::CODE_E;
      wr.codes[3] = ssd_pkg::CODE_BLANK;
      wr.codes[4] = ssd_pkg::CODE_BLANK;
      wr.codes[5] = ssd_pkg::CODE_BLANK;
      wr.codes[6] = light_t4;
      wr.codes[7] = light_o4;
    end
  end

  // Store, scan and result register
  ssd_display u_display (
    .clk          (clk),
    .rst          (rst),
    .req_valid    (v4),
    .req_op       (op4),
    .wr           (wr),
    .out_ready    (m_tready),
    .out_valid    (m_tvalid),
    .out_select   (m_tdata[7:0]),
    .out_segments (m_tdata[15:8]),
    .advance      (advance)
  );

endmodule

`default_nettype wire
